>>> rtl/core/bskpe_pkg.sv
// shared types and constants for the branch sample kernel pc extractor
// no dependencies
package bskpe_pkg;

    localparam int          WORD_W          = 64;
    localparam int          TYPE_W          = 32;
    localparam int          SIZE_W          = 13;
    localparam int          ENTRY_W         = 6;
    localparam int          COUNT_W         = 32;
    localparam int          MAX_ENTRIES_DEF = 32;
    localparam logic [63:0] THRESHOLD_RST   = 64'hffff_8000_0000_0000;
    localparam logic [31:0] RECORD_TYPE_RST = 32'd9;

    typedef enum logic [0:0] {
        REG_KERNEL_THRESHOLD = 1'b0,
        REG_RECORD_TYPE      = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_IP     = 3'd2,
        PH_COUNT  = 3'd3,
        PH_ENTRY  = 3'd4,
        PH_TAIL   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        SLOT_FROM  = 2'd0,
        SLOT_TO    = 2'd1,
        SLOT_FLAGS = 2'd2
    } slot_t;

    typedef enum logic [1:0] {
        SRC_IP   = 2'd0,
        SRC_FROM = 2'd1,
        SRC_TO   = 2'd2
    } pc_src_t;

    typedef struct packed {
        logic [WORD_W-1:0] kernel_threshold;
        logic [TYPE_W-1:0] sample_record_type;
    } cfg_t;

    typedef struct packed {
        logic               emit;
        logic [WORD_W-1:0]  pc;
        pc_src_t            src;
        logic [COUNT_W-1:0] total;
    } result_t;

endpackage

>>> rtl/core/bskpe_cfg_regs.sv
// configuration registers: kernel threshold and sample record type
// depends on bskpe_pkg
module bskpe_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [bskpe_pkg::WORD_W-1:0]   cfg_data,
    output bskpe_pkg::cfg_t                cfg
);
    import bskpe_pkg::*;

    logic [WORD_W-1:0] threshold_reg;
    logic [TYPE_W-1:0] record_type_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= THRESHOLD_RST;
            record_type_reg <= RECORD_TYPE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_KERNEL_THRESHOLD: threshold_reg   <= cfg_data;
                REG_RECORD_TYPE:      record_type_reg <= cfg_data[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.kernel_threshold   = threshold_reg;
    assign cfg.sample_record_type = record_type_reg;

endmodule

>>> rtl/core/bskpe_parser.sv
// record parser: header decode, record walk, kernel address compare, count
// depends on bskpe_pkg
module bskpe_parser #(
    parameter int MAX_ENTRIES = bskpe_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [bskpe_pkg::WORD_W-1:0]   data_word,
    input  logic                           start_of_batch,
    input  bskpe_pkg::cfg_t                cfg,
    output bskpe_pkg::result_t             result
);
    import bskpe_pkg::*;

    localparam logic [WORD_W-1:0]  MaxEntWide = WORD_W'(MAX_ENTRIES);
    localparam logic [ENTRY_W-1:0] MaxEntNarrow = ENTRY_W'(MAX_ENTRIES);

    phase_t             phase_reg, phase_next;
    logic [SIZE_W-1:0]  left_reg, left_next;
    logic [ENTRY_W-1:0] entries_reg, entries_next;
    slot_t              slot_reg, slot_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    phase_t             phase_cur;
    logic [SIZE_W-1:0]  left_cur;
    logic [ENTRY_W-1:0] entries_cur;
    slot_t              slot_cur;
    logic [COUNT_W-1:0] count_cur;
    logic [SIZE_W-1:0]  hdr_words;
    logic [ENTRY_W-1:0] entries_dec;
    logic               is_kernel;
    logic               emit_en;
    pc_src_t            emit_src;

    // batch restart applies before this word is parsed
    always_comb begin
        if (start_of_batch) begin
            phase_cur   = PH_HEADER;
            left_cur    = '0;
            entries_cur = '0;
            slot_cur    = SLOT_FROM;
            count_cur   = '0;
        end else begin
            phase_cur   = phase_reg;
            left_cur    = left_reg;
            entries_cur = entries_reg;
            slot_cur    = slot_reg;
            count_cur   = count_reg;
        end
    end

    assign hdr_words = (data_word[63:51] == '0) ? SIZE_W'(1) : data_word[63:51];
    assign entries_dec = (entries_cur != '0) ? entries_cur - ENTRY_W'(1) : entries_cur;
    assign is_kernel = (data_word >= cfg.kernel_threshold);

    // next state
    always_comb begin
        phase_next   = phase_cur;
        left_next    = left_cur;
        entries_next = entries_cur;
        slot_next    = slot_cur;
        if (phase_cur == PH_HEADER) begin
            left_next    = hdr_words - SIZE_W'(1);
            entries_next = '0;
            slot_next    = SLOT_FROM;
            if (left_next == '0) begin
                phase_next = PH_HEADER;
            end else if (data_word[TYPE_W-1:0] == cfg.sample_record_type) begin
                phase_next = PH_IP;
            end else begin
                phase_next = PH_SKIP;
            end
        end else begin
            if (left_cur != '0) begin
                left_next = left_cur - SIZE_W'(1);
            end
            case (phase_cur)
                PH_IP: begin
                    phase_next = PH_COUNT;
                end
                PH_COUNT: begin
                    entries_next = (data_word < MaxEntWide) ? data_word[ENTRY_W-1:0]
                                                            : MaxEntNarrow;
                    slot_next    = SLOT_FROM;
                    phase_next   = (entries_next == '0) ? PH_TAIL : PH_ENTRY;
                end
                PH_ENTRY: begin
                    case (slot_cur)
                        SLOT_FROM: slot_next = SLOT_TO;
                        SLOT_TO:   slot_next = SLOT_FLAGS;
                        default: begin
                            slot_next    = SLOT_FROM;
                            entries_next = entries_dec;
                            if (entries_dec == '0) begin
                                phase_next = PH_TAIL;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
            // record boundary cuts off whatever comes next
            if (left_next == '0) begin
                phase_next   = PH_HEADER;
                entries_next = '0;
                slot_next    = SLOT_FROM;
            end
        end
    end

    // outputs
    always_comb begin
        emit_en  = 1'b0;
        emit_src = SRC_IP;
        case (phase_cur)
            PH_IP: begin
                emit_en  = is_kernel;
                emit_src = SRC_IP;
            end
            PH_ENTRY: begin
                case (slot_cur)
                    SLOT_FROM: begin
                        emit_en  = is_kernel;
                        emit_src = SRC_FROM;
                    end
                    SLOT_TO: begin
                        emit_en  = is_kernel;
                        emit_src = SRC_TO;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        count_next = (emit_en && count_cur != '1) ? count_cur + COUNT_W'(1) : count_cur;
    end

    assign result.emit  = emit_en;
    assign result.pc    = data_word;
    assign result.src   = emit_src;
    assign result.total = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            left_reg    <= '0;
            entries_reg <= '0;
            slot_reg    <= SLOT_FROM;
            count_reg   <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            entries_reg <= entries_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
        end
    end

endmodule

>>> rtl/core/bskpe_out_reg.sv
// result register holding one transaction for the output channel
// depends on bskpe_pkg
module bskpe_out_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  bskpe_pkg::result_t              result,
    output logic                            in_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bskpe_pkg::WORD_W-1:0]    m_kernel_pc,
    output logic [1:0]                      m_pc_source,
    output logic [bskpe_pkg::COUNT_W-1:0]   m_pc_total
);
    import bskpe_pkg::*;

    logic               valid_reg, valid_next;
    logic [WORD_W-1:0]  pc_reg;
    pc_src_t            src_reg;
    logic [COUNT_W-1:0] total_reg;
    logic               load;

    assign in_ready = !valid_reg || m_ready;
    assign load     = accept && result.emit;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pc_reg    <= result.pc;
            src_reg   <= result.src;
            total_reg <= result.total;
        end
    end

    assign m_valid     = valid_reg;
    assign m_kernel_pc = pc_reg;
    assign m_pc_source = src_reg;
    assign m_pc_total  = total_reg;

endmodule

>>> rtl/core/branch_sample_kernel_pc_extractor_unit.sv
// top level: kernel pc extractor over a stream of sampled branch records
// one word per transaction; a kernel address appears in the cycle after its word is accepted
// throughput one word per cycle unless input ready drops, set by the single parse step feeding the result register
// input ready drops only while a result waits and m_ready is low
// synchronous active-low reset: parser at a record header, count zero, output empty,
// threshold 0xffff800000000000 and sample type 9
module branch_sample_kernel_pc_extractor_unit #(
    parameter int MAX_ENTRIES = bskpe_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bskpe_pkg::WORD_W-1:0]    s_data_word,
    input  logic                            s_start_of_batch,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bskpe_pkg::WORD_W-1:0]    m_kernel_pc,
    output logic [1:0]                      m_pc_source,
    output logic [bskpe_pkg::COUNT_W-1:0]   m_pc_total,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [bskpe_pkg::WORD_W-1:0]    cfg_data
);
    import bskpe_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    accept;

    assign accept = s_valid && s_ready;

    bskpe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bskpe_parser #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_word      (s_data_word),
        .start_of_batch (s_start_of_batch),
        .cfg            (cfg),
        .result         (result)
    );

    bskpe_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .result      (result),
        .in_ready    (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kernel_pc (m_kernel_pc),
        .m_pc_source (m_pc_source),
        .m_pc_total  (m_pc_total)
    );

endmodule
